/* hw/rtl/photometric_stereo_pixel_macros.svh */
// Assertion macros for the photometric stereo pixel block.
// Used by the top level only; relies on a clock named clock and a reset named reset.
`ifndef PHOTOMETRIC_STEREO_PIXEL_MACROS_SVH
`define PHOTOMETRIC_STEREO_PIXEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/psp_pkg.sv */
// Shared constants, types and register codes of the photometric stereo pixel block.
// No dependencies; imported by every module of the block.
package psp_pkg;

   localparam int COORD_BITS = 10;
   localparam int COEF_BITS  = 16;

   localparam int LUM_W      = 8;
   localparam int COORD_W    = 10;
   localparam int ROW_W      = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int ALB_W      = 24;
   localparam int NORM_W     = 16;

   localparam int V_W        = COEF_BITS + LUM_W + 2;
   localparam int MUL_W      = V_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int SUMSQ_W    = 2 * V_W;
   localparam int FRAC_SHIFT = 8;
   localparam int SQ_IN_W    = SUMSQ_W - FRAC_SHIFT;
   localparam int ROOT_W     = SQ_IN_W / 2;
   localparam int CS_W       = SQ_IN_W;

   localparam int NORM_SHIFT = 10;
   localparam int Q_W        = 14;
   localparam int SAT_SHIFT  = Q_W - NORM_SHIFT;

   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_ZERO  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_ONE   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_TWO   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_STEP = 3'd4;

   localparam logic [ROW_W-1:0] ROW_ZERO_RESET = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_ONE_RESET  = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_TWO_RESET  = 48'h1000_0000_0000;
   localparam logic [LUM_W-1:0] THRESHOLD_RESET = 8'd1;
   localparam logic [LUM_W-1:0] GRID_STEP_RESET = 8'd8;

   typedef struct packed {
      logic            ge;
      logic [CS_W-1:0] diff;
   } csub_res_type;

endpackage

/* hw/rtl/psp_mul.sv */
// Registered signed multiplier shared by the matrix product and the squares.
// Depends on psp_pkg.
module psp_mul
   import psp_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  mul_a,
   input  logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* hw/rtl/psp_csub.sv */
// Shared compare and subtract step used by the square root, the saturation check, the divides and the grid test.
// Depends on psp_pkg.
module psp_csub
   import psp_pkg::*;
(
   input  logic [CS_W-1:0] op_a,
   input  logic [CS_W-1:0] op_b,
   output csub_res_type    res
);

   assign res.ge   = (op_a >= op_b);
   assign res.diff = op_a - op_b;

endmodule

/* hw/rtl/photometric_stereo_pixel.sv */
// Top level of the photometric stereo pixel block: sequencer, registers and ports.
// Depends on psp_pkg, psp_mul, psp_csub and photometric_stereo_pixel_macros.svh.
//
// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata intensities, row, column; tuser frame start
// rsp_      out        rsp_tvalid/tready    tdata albedo, normals, max; tuser dark, grid
// csr_      in         csr_wen              csr_addr register index, csr_wdata value
//
// A lit pixel runs the matrix product and the squares on the one multiplier, the root,
// then per normal component a saturation check and, unless it saturates or the albedo is
// zero, a divide on the compare-subtract unit, then the grid test and the output load. A
// dark pixel goes from acceptance straight to the output load. Either load waits until the
// output register is free; the next word can enter in the cycle after the load. Reset is synchronous
// and active high. A finished result waits in the output register while the next word enters.
`include "photometric_stereo_pixel_macros.svh"
module photometric_stereo_pixel
   import psp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] intensity_one, [15:8] intensity_two, [23:16] intensity_three,
   // [33:24] pixel_row, [43:34] pixel_column, [47:44] zero
   input  logic [47:0]           req_tdata,
   // [0] frame_start
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [23:0] albedo, [39:24] normal_x, [55:40] normal_y, [71:56] normal_z,
   // [95:72] max_albedo
   output logic [95:0]           rsp_tdata,
   // [0] is_dark, [1] on_grid
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [ROW_W-1:0]      csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MAC  = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_DCHK = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_GRID = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   localparam logic [4:0] MAC_LAST  = 5'd9;
   localparam logic [4:0] SQ_ISSUES = 5'd3;
   localparam logic [4:0] SQ_LAST   = 5'd4;
   localparam logic [4:0] ROOT_LAST = 5'(ROOT_W - 1);
   localparam logic [4:0] DIV_LAST  = 5'(Q_W - 1);
   localparam logic [4:0] ROW_LAST  = 5'(COORD_BITS - 1);
   localparam logic [4:0] COL_LAST  = 5'(2 * COORD_BITS - 1);
   localparam logic [CS_W-1:0] BIT_START = CS_W'(1) << (2 * (ROOT_W - 1));
   localparam logic [NORM_W-1:0] UNIT_POS = NORM_W'(1) << Q_W;

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [1:0]           kidx_ff, kidx_in;
   logic [1:0]           hidx_ff, hidx_in;
   logic                 pend_ff, pend_in;
   logic [1:0]           pk_ff, pk_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]     mrow_ff [3];
   logic [ROW_W-1:0]     mrow_in [3];
   logic [LUM_W-1:0]     thr_ff, thr_in;
   logic [LUM_W-1:0]     step_ff, step_in;
   logic [ALB_W-1:0]     runmax_ff, runmax_in;

   // Working payload.
   logic [LUM_W-1:0]         lum_ff [3];
   logic [LUM_W-1:0]         lum_in [3];
   logic [2*COORD_BITS-1:0]  gsh_ff, gsh_in;
   logic                     dark_ff, dark_in;
   logic signed [V_W-1:0]    v_ff [3];
   logic signed [V_W-1:0]    v_in [3];
   logic [SUMSQ_W-1:0]       sumsq_ff, sumsq_in;
   logic [CS_W-1:0]          x_ff, x_in;
   logic [CS_W-1:0]          res_ff, res_in;
   logic [CS_W-1:0]          bit_ff, bit_in;
   logic [ROOT_W-1:0]        alb_ff, alb_in;
   logic [ROOT_W-1:0]        rem_ff, rem_in;
   logic [Q_W-1:0]           dd_ff, dd_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [NORM_W-1:0]        norm_ff [3];
   logic [NORM_W-1:0]        norm_in [3];
   logic [LUM_W-1:0]         grem_ff, grem_in;
   logic                     rowz_ff, rowz_in;
   logic                     grid_ff, grid_in;

   // Output register.
   logic [ALB_W-1:0]   out_alb_ff, out_alb_in;
   logic [NORM_W-1:0]  out_n_ff [3];
   logic [NORM_W-1:0]  out_n_in [3];
   logic               out_dark_ff, out_dark_in;
   logic               out_grid_ff, out_grid_in;
   logic [ALB_W-1:0]   out_max_ff, out_max_in;

   // Shared units.
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [CS_W-1:0]          cs_a, cs_b;
   csub_res_type             cs_res;

   // Helpers.
   logic                     req_acc;
   logic                     out_free;
   logic [COEF_BITS-1:0]     coef;
   logic signed [V_W-1:0]    vk;
   logic [V_W-1:0]           mag;
   logic [ROOT_W:0]          rem2;
   logic [Q_W-1:0]           q_next;
   logic [NORM_W-1:0]        q_ext;
   logic [LUM_W:0]           grem2;
   logic [LUM_W-1:0]         grem_next;
   logic [LUM_W-1:0]         step_eff;
   logic [ALB_W-1:0]         alb_wide;
   logic                     advance;
   logic [NORM_W-1:0]        advance_val;

   psp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   psp_csub u_csub (
      .op_a (cs_a),
      .op_b (cs_b),
      .res  (cs_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_max_ff, out_n_ff[2], out_n_ff[1], out_n_ff[0], out_alb_ff};
   assign rsp_tuser  = {out_grid_ff, out_dark_ff};

   // A grid step of zero behaves as one.
   assign step_eff = (step_ff == '0) ? LUM_W'(1) : step_ff;
   assign alb_wide = ALB_W'(alb_ff);

   assign coef = mrow_ff[kidx_ff][hidx_ff*COEF_BITS +: COEF_BITS];
   assign vk   = v_ff[kidx_ff];
   assign mag  = vk[V_W-1] ? V_W'(-vk) : V_W'(vk);
   assign rem2 = {rem_ff, dd_ff[Q_W-1]};
   assign q_next = {q_ff[Q_W-2:0], cs_res.ge};
   assign q_ext  = NORM_W'(q_next);
   assign grem2  = {grem_ff, gsh_ff[2*COORD_BITS-1]};
   assign grem_next = cs_res.ge ? cs_res.diff[LUM_W-1:0] : grem2[LUM_W-1:0];

   // Multiplier operands: coefficient times intensity, then the squares of v.
   always_comb begin
      if (state_ff == S_MAC) begin
         mul_a = {{(MUL_W-COEF_BITS){coef[COEF_BITS-1]}}, coef};
         mul_b = MUL_W'(lum_ff[hidx_ff]);
      end else begin
         mul_a = vk;
         mul_b = vk;
      end
   end

   // Compare-subtract operands for each phase that borrows the unit.
   always_comb begin
      unique case (state_ff)
         S_SQRT: begin
            cs_a = x_ff;
            cs_b = res_ff + bit_ff;
         end
         S_DCHK: begin
            cs_a = CS_W'(mag);
            cs_b = CS_W'(alb_ff) << SAT_SHIFT;
         end
         S_DIV: begin
            cs_a = CS_W'(rem2);
            cs_b = CS_W'(alb_ff);
         end
         S_GRID: begin
            cs_a = CS_W'(grem2);
            cs_b = CS_W'(step_eff);
         end
         default: begin
            cs_a = '0;
            cs_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kidx_in      = kidx_ff;
      hidx_in      = hidx_ff;
      pend_in      = 1'b0;
      pk_in        = pk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mrow_in      = mrow_ff;
      thr_in       = thr_ff;
      step_in      = step_ff;
      runmax_in    = runmax_ff;
      lum_in       = lum_ff;
      gsh_in       = gsh_ff;
      dark_in      = dark_ff;
      v_in         = v_ff;
      sumsq_in     = sumsq_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      alb_in       = alb_ff;
      rem_in       = rem_ff;
      dd_in        = dd_ff;
      q_in         = q_ff;
      norm_in      = norm_ff;
      grem_in      = grem_ff;
      rowz_in      = rowz_ff;
      grid_in      = grid_ff;
      out_alb_in   = out_alb_ff;
      out_n_in     = out_n_ff;
      out_dark_in  = out_dark_ff;
      out_grid_in  = out_grid_ff;
      out_max_in   = out_max_ff;
      advance      = 1'b0;
      advance_val  = '0;

      if (csr_wen) begin
         unique case (csr_addr)
            CSR_ROW_ZERO:  mrow_in[0] = csr_wdata;
            CSR_ROW_ONE:   mrow_in[1] = csr_wdata;
            CSR_ROW_TWO:   mrow_in[2] = csr_wdata;
            CSR_THRESHOLD: thr_in     = csr_wdata[LUM_W-1:0];
            CSR_GRID_STEP: step_in    = csr_wdata[LUM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               lum_in[0] = req_tdata[7:0];
               lum_in[1] = req_tdata[15:8];
               lum_in[2] = req_tdata[23:16];
               gsh_in    = {req_tdata[24 +: COORD_BITS], req_tdata[34 +: COORD_BITS]};
               dark_in   = (req_tdata[7:0] < thr_ff) || (req_tdata[15:8] < thr_ff) ||
                           (req_tdata[23:16] < thr_ff);
               if (req_tuser) begin
                  runmax_in = '0;
               end
               v_in     = '{default: '0};
               sumsq_in = '0;
               cnt_in   = '0;
               kidx_in  = '0;
               hidx_in  = '0;
               state_in = dark_in ? S_DONE : S_MAC;
            end
         end
         S_MAC: begin
            if (cnt_ff < MAC_LAST) begin
               pend_in = 1'b1;
               pk_in   = kidx_ff;
               if (hidx_ff == 2'd2) begin
                  hidx_in = '0;
                  kidx_in = kidx_ff + 2'd1;
               end else begin
                  hidx_in = hidx_ff + 2'd1;
               end
            end
            if (pend_ff) begin
               v_in[pk_ff] = v_ff[pk_ff] + prod[V_W-1:0];
            end
            if (cnt_ff == MAC_LAST) begin
               state_in = S_SQ;
               cnt_in   = '0;
               kidx_in  = '0;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SQ: begin
            if (cnt_ff < SQ_ISSUES) begin
               pend_in = 1'b1;
               kidx_in = kidx_ff + 2'd1;
            end
            if (pend_ff) begin
               sumsq_in = sumsq_ff + SUMSQ_W'(prod);
            end
            if (cnt_ff == SQ_LAST) begin
               x_in     = sumsq_ff[SUMSQ_W-1:FRAC_SHIFT];
               res_in   = '0;
               bit_in   = BIT_START;
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SQRT: begin
            // One root bit per cycle: subtract the trial value when it fits.
            if (cs_res.ge) begin
               x_in   = cs_res.diff;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) begin
               alb_in   = res_in[ROOT_W-1:0];
               kidx_in  = '0;
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            // Zero albedo gives a zero normal; mag >= 16*albedo saturates.
            if (alb_ff == '0) begin
               advance     = 1'b1;
               advance_val = '0;
            end else if (cs_res.ge) begin
               advance     = 1'b1;
               advance_val = vk[V_W-1] ? NORM_W'(-UNIT_POS) : UNIT_POS;
            end else begin
               rem_in   = ROOT_W'(mag >> SAT_SHIFT);
               dd_in    = {mag[SAT_SHIFT-1:0], {NORM_SHIFT{1'b0}}};
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = cs_res.ge ? cs_res.diff[ROOT_W-1:0] : rem2[ROOT_W-1:0];
            q_in   = q_next;
            dd_in  = {dd_ff[Q_W-2:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               advance     = 1'b1;
               advance_val = vk[V_W-1] ? NORM_W'(-q_ext) : q_ext;
            end
         end
         S_GRID: begin
            grem_in = grem_next;
            gsh_in  = {gsh_ff[2*COORD_BITS-2:0], 1'b0};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == ROW_LAST) begin
               rowz_in = (grem_next == '0);
               grem_in = '0;
            end
            if (cnt_ff == COL_LAST) begin
               grid_in  = rowz_ff && (grem_next == '0);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_dark_in  = dark_ff;
               if (dark_ff) begin
                  out_alb_in  = '0;
                  out_n_in    = '{default: '0};
                  out_grid_in = 1'b0;
                  out_max_in  = runmax_ff;
               end else begin
                  out_alb_in  = alb_wide;
                  out_n_in    = norm_ff;
                  out_grid_in = grid_ff;
                  if (alb_wide > runmax_ff) begin
                     runmax_in  = alb_wide;
                     out_max_in = alb_wide;
                  end else begin
                     out_max_in = runmax_ff;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Store one normal component and move to the next, or on to the grid test.
      if (advance) begin
         norm_in[kidx_ff] = advance_val;
         if (kidx_ff == 2'd2) begin
            cnt_in   = '0;
            grem_in  = '0;
            state_in = S_GRID;
         end else begin
            kidx_in  = kidx_ff + 2'd1;
            state_in = S_DCHK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         kidx_ff      <= '0;
         hidx_ff      <= '0;
         pend_ff      <= 1'b0;
         pk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         mrow_ff[0]   <= ROW_ZERO_RESET;
         mrow_ff[1]   <= ROW_ONE_RESET;
         mrow_ff[2]   <= ROW_TWO_RESET;
         thr_ff       <= THRESHOLD_RESET;
         step_ff      <= GRID_STEP_RESET;
         runmax_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kidx_ff      <= kidx_in;
         hidx_ff      <= hidx_in;
         pend_ff      <= pend_in;
         pk_ff        <= pk_in;
         rsp_valid_ff <= rsp_valid_in;
         mrow_ff      <= mrow_in;
         thr_ff       <= thr_in;
         step_ff      <= step_in;
         runmax_ff    <= runmax_in;
      end
   end

   always_ff @(posedge clock) begin
      lum_ff      <= lum_in;
      gsh_ff      <= gsh_in;
      dark_ff     <= dark_in;
      v_ff        <= v_in;
      sumsq_ff    <= sumsq_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      alb_ff      <= alb_in;
      rem_ff      <= rem_in;
      dd_ff       <= dd_in;
      q_ff        <= q_in;
      norm_ff     <= norm_in;
      grem_ff     <= grem_in;
      rowz_ff     <= rowz_in;
      grid_ff     <= grid_in;
      out_alb_ff  <= out_alb_in;
      out_n_ff    <= out_n_in;
      out_dark_ff <= out_dark_in;
      out_grid_ff <= out_grid_in;
      out_max_ff  <= out_max_in;
   end

   `PSP_ASSERT_NEXT(a_accept_leaves_idle, req_acc, state_ff != S_IDLE, "accepted word did not start work")
   `PSP_ASSERT_NOW(a_dark_zero, rsp_valid_ff && out_dark_ff, (out_alb_ff == '0) && !out_grid_ff && (rsp_tdata[71:24] == '0), "dark result not zero")
   `PSP_ASSERT_NOW(a_max_bounds, rsp_valid_ff, out_max_ff >= out_alb_ff, "max albedo below albedo")
   `PSP_ASSERT_NOW(a_one_pending, pend_ff, (state_ff == S_MAC) || (state_ff == S_SQ), "product pending outside multiply phases")

endmodule
